FILE: src/calu_pkg.sv
`timescale 1ns / 1ps

package calu_pkg;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WIDE_W  = 16;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned FLAGS_W = 4;

  // Flag bit positions inside a flags word.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 5'd0,
    KIND_ADC   = 5'd1,
    KIND_SUB   = 5'd2,
    KIND_SBC   = 5'd3,
    KIND_AND   = 5'd4,
    KIND_XOR   = 5'd5,
    KIND_OR    = 5'd6,
    KIND_CP    = 5'd7,
    KIND_INC   = 5'd8,
    KIND_DEC   = 5'd9,
    KIND_RLC   = 5'd10,
    KIND_RRC   = 5'd11,
    KIND_RL    = 5'd12,
    KIND_RR    = 5'd13,
    KIND_SLA   = 5'd14,
    KIND_SRA   = 5'd15,
    KIND_SWAP  = 5'd16,
    KIND_SRL   = 5'd17,
    KIND_RLCA  = 5'd18,
    KIND_RRCA  = 5'd19,
    KIND_RLA   = 5'd20,
    KIND_RRA   = 5'd21,
    KIND_BIT   = 5'd22,
    KIND_RES   = 5'd23,
    KIND_SET   = 5'd24,
    KIND_DAA   = 5'd25,
    KIND_CPL   = 5'd26,
    KIND_SCF   = 5'd27,
    KIND_CCF   = 5'd28,
    KIND_ADD16 = 5'd29,
    KIND_ADDSP = 5'd30
  } kind_t;

  // Shift and rotate flavor shared by the CB group and the accumulator group.
  typedef enum logic [2:0] {
    ROT_RLC  = 3'd0,
    ROT_RRC  = 3'd1,
    ROT_RL   = 3'd2,
    ROT_RR   = 3'd3,
    ROT_SLA  = 3'd4,
    ROT_SRA  = 3'd5,
    ROT_SWAP = 3'd6,
    ROT_SRL  = 3'd7
  } rot_t;

  // First stage: captured operands plus the narrow carry terms.
  typedef struct packed {
    kind_t              kind;
    rot_t               rot;
    logic [BYTE_W-1:0]  a;
    logic [BYTE_W-1:0]  b;
    logic [BIDX_W-1:0]  bidx;
    logic [FLAGS_W-1:0] f;
    logic [WIDE_W-1:0]  wa;
    logic [WIDE_W-1:0]  wb;
    logic               cy;
    logic               h_add;
    logic               h_sub;
    logic               h_wide;
    logic               sp_h;
    logic               sp_c;
    logic [BYTE_W-1:0]  daa_adj;
    logic               daa_c;
  } stage1_t;

  // Second stage: raw byte result and every flag except a computed Z.
  typedef struct packed {
    logic [BYTE_W-1:0] r_calc;
    logic              clear_r;
    logic [WIDE_W-1:0] wr;
    logic              z_from_r;
    logic              z_fixed;
    logic              n;
    logic              h;
    logic              c;
    logic              wrt;
  } stage2_t;

  // Third stage: the finished result item.
  typedef struct packed {
    logic [BYTE_W-1:0]  result;
    logic [WIDE_W-1:0]  wide_result;
    logic [FLAGS_W-1:0] flags;
    logic               writes;
  } stage3_t;

endpackage

FILE: src/calu_if.sv
`timescale 1ns / 1ps

interface calu_in_if;
  logic                               valid;
  logic                               ready;
  logic [calu_pkg::KIND_W-1:0]        kind;
  logic [calu_pkg::BYTE_W-1:0]        operand_a;
  logic [calu_pkg::BYTE_W-1:0]        operand_b;
  logic [calu_pkg::BIDX_W-1:0]        bit_index;
  logic [calu_pkg::FLAGS_W-1:0]       flags_in;
  logic [calu_pkg::WIDE_W-1:0]        wide_a;
  logic [calu_pkg::WIDE_W-1:0]        wide_b;

  modport source (
    output valid, kind, operand_a, operand_b, bit_index, flags_in, wide_a, wide_b,
    input  ready
  );
  modport sink (
    input  valid, kind, operand_a, operand_b, bit_index, flags_in, wide_a, wide_b,
    output ready
  );
endinterface

interface calu_out_if;
  logic                               valid;
  logic                               ready;
  logic [calu_pkg::BYTE_W-1:0]        result;
  logic [calu_pkg::WIDE_W-1:0]        wide_result;
  logic [calu_pkg::FLAGS_W-1:0]       flags_out;
  logic                               writes_result;

  modport source (
    output valid, result, wide_result, flags_out, writes_result,
    input  ready
  );
  modport sink (
    input  valid, result, wide_result, flags_out, writes_result,
    output ready
  );
endinterface

FILE: src/cpu_alu_with_flags.sv
`timescale 1ns / 1ps

// ALU with flags for an 8-bit handheld-console CPU core.
// Operations arrive on in_ch: an operation kind, two byte operands, a bit
// index, two 16-bit operands and the incoming Z/N/H/C flags. Each operation
// produces exactly one result on out_ch: the byte result, the 16-bit result,
// the new flags and a bit telling whether the destination register is written.
// Both channels use valid/ready; a transfer happens on a rising clock edge
// with valid and ready both high.
// An operation passes through the three register stages in order (operand
// capture with the narrow carry terms, the 8- and 16-bit adders, zero detect
// and packing); out_ch.valid rises once the item is held in the last one.
// Throughput is one operation per cycle while out_ch.ready stays high: each
// stage takes a new item whenever the stage after it moves or is empty.
// When the receiver holds out_ch.ready low, the stages fill up behind the
// output register, and in_ch.ready drops only once all three hold an item;
// nothing is dropped or repeated.
// rst_n is a synchronous active-low reset that empties all stages; no
// result is presented until a new operation is transferred in.
module cpu_alu_with_flags (
  input  logic       clk,
  input  logic       rst_n,
  calu_in_if.sink    in_ch,
  calu_out_if.source out_ch
);

  // Pipeline valid bits and stage registers.
  logic              v1_r, v2_r, v3_r;
  calu_pkg::stage1_t s1_r, s1_nxt;
  calu_pkg::stage2_t s2_r, s2_nxt;
  calu_pkg::stage3_t s3_r, s3_nxt;

  // A stage loads when it is empty or its contents move on in this cycle.
  logic en1, en2, en3;

  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  // Stage 1: capture the operands and work out the narrow carry terms,
  // the shift flavor and the decimal adjust value.
  always_comb begin
    calu_pkg::kind_t   k;
    logic [4:0]        nib_add;
    logic [4:0]        nib_sub;
    logic [12:0]       low12;
    logic [4:0]        sp_nib;
    logic [8:0]        sp_low;
    logic              fn, fh, fc;
    logic              daa_lo, daa_hi;
    k        = calu_pkg::kind_t'(in_ch.kind);
    fn       = in_ch.flags_in[calu_pkg::FLAG_N];
    fh       = in_ch.flags_in[calu_pkg::FLAG_H];
    fc       = in_ch.flags_in[calu_pkg::FLAG_C];

    s1_nxt.kind = k;
    s1_nxt.a    = in_ch.operand_a;
    s1_nxt.b    = in_ch.operand_b;
    s1_nxt.bidx = in_ch.bit_index;
    s1_nxt.f    = in_ch.flags_in;
    s1_nxt.wa   = in_ch.wide_a;
    s1_nxt.wb   = in_ch.wide_b;

    // The accumulator rotates reuse the CB shift encodings.
    if (in_ch.kind >= calu_pkg::KIND_RLCA) begin
      s1_nxt.rot = calu_pkg::rot_t'(3'(in_ch.kind - calu_pkg::KIND_RLCA));
    end else begin
      s1_nxt.rot = calu_pkg::rot_t'(3'(in_ch.kind - calu_pkg::KIND_RLC));
    end

    s1_nxt.cy = fc && ((k == calu_pkg::KIND_ADC) || (k == calu_pkg::KIND_SBC));

    nib_add = {1'b0, in_ch.operand_a[3:0]} + {1'b0, in_ch.operand_b[3:0]}
            + {4'd0, s1_nxt.cy};
    nib_sub = {1'b0, in_ch.operand_b[3:0]} + {4'd0, s1_nxt.cy};
    s1_nxt.h_add = nib_add[4];
    s1_nxt.h_sub = {1'b0, in_ch.operand_a[3:0]} < nib_sub;

    low12 = {1'b0, in_ch.wide_a[11:0]} + {1'b0, in_ch.wide_b[11:0]};
    s1_nxt.h_wide = low12[12];

    sp_nib = {1'b0, in_ch.wide_a[3:0]} + {1'b0, in_ch.operand_b[3:0]};
    sp_low = {1'b0, in_ch.wide_a[7:0]} + {1'b0, in_ch.operand_b};
    s1_nxt.sp_h = sp_nib[4];
    s1_nxt.sp_c = sp_low[8];

    daa_lo = fh || (!fn && (in_ch.operand_a[3:0] > 4'h9));
    daa_hi = fc || (!fn && (in_ch.operand_a > 8'h99));
    s1_nxt.daa_adj = (daa_lo ? 8'h06 : 8'h00) | (daa_hi ? 8'h60 : 8'h00);
    s1_nxt.daa_c   = daa_hi;
  end

  // Stage 2: the full-width adders, logic, shift, bit and flag operations.
  always_comb begin
    logic [8:0]  sum9;
    logic [8:0]  dif9;
    logic [16:0] sum17;
    logic        fz, fn, fh, fc;
    logic [7:0]  a;
    a     = s1_r.a;
    fz    = s1_r.f[calu_pkg::FLAG_Z];
    fn    = s1_r.f[calu_pkg::FLAG_N];
    fh    = s1_r.f[calu_pkg::FLAG_H];
    fc    = s1_r.f[calu_pkg::FLAG_C];
    sum9  = {1'b0, a} + {1'b0, s1_r.b} + {8'd0, s1_r.cy};
    dif9  = {1'b0, a} - {1'b0, s1_r.b} - {8'd0, s1_r.cy};
    sum17 = {1'b0, s1_r.wa} + {1'b0, s1_r.wb};

    // Unless an operation says otherwise, flags pass through unchanged.
    s2_nxt.r_calc   = 8'd0;
    s2_nxt.clear_r  = 1'b0;
    s2_nxt.wr       = 16'd0;
    s2_nxt.z_from_r = 1'b0;
    s2_nxt.z_fixed  = fz;
    s2_nxt.n        = fn;
    s2_nxt.h        = fh;
    s2_nxt.c        = fc;
    s2_nxt.wrt      = 1'b1;

    case (s1_r.kind)
      calu_pkg::KIND_ADD, calu_pkg::KIND_ADC: begin
        s2_nxt.r_calc   = sum9[7:0];
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.n        = 1'b0;
        s2_nxt.h        = s1_r.h_add;
        s2_nxt.c        = sum9[8];
      end
      calu_pkg::KIND_SUB, calu_pkg::KIND_SBC, calu_pkg::KIND_CP: begin
        s2_nxt.r_calc   = dif9[7:0];
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.n        = 1'b1;
        s2_nxt.h        = s1_r.h_sub;
        s2_nxt.c        = dif9[8];
        // Compare keeps only the flags.
        if (s1_r.kind == calu_pkg::KIND_CP) begin
          s2_nxt.clear_r = 1'b1;
          s2_nxt.wrt     = 1'b0;
        end
      end
      calu_pkg::KIND_AND: begin
        s2_nxt.r_calc   = a & s1_r.b;
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.n        = 1'b0;
        s2_nxt.h        = 1'b1;
        s2_nxt.c        = 1'b0;
      end
      calu_pkg::KIND_XOR, calu_pkg::KIND_OR: begin
        s2_nxt.r_calc   = (s1_r.kind == calu_pkg::KIND_XOR) ? (a ^ s1_r.b) : (a | s1_r.b);
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.n        = 1'b0;
        s2_nxt.h        = 1'b0;
        s2_nxt.c        = 1'b0;
      end
      calu_pkg::KIND_INC: begin
        s2_nxt.r_calc   = a + 8'd1;
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.n        = 1'b0;
        s2_nxt.h        = (a[3:0] == 4'hF);
      end
      calu_pkg::KIND_DEC: begin
        s2_nxt.r_calc   = a - 8'd1;
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.n        = 1'b1;
        s2_nxt.h        = (a[3:0] == 4'h0);
      end
      calu_pkg::KIND_RLC, calu_pkg::KIND_RRC, calu_pkg::KIND_RL, calu_pkg::KIND_RR,
      calu_pkg::KIND_SLA, calu_pkg::KIND_SRA, calu_pkg::KIND_SWAP, calu_pkg::KIND_SRL,
      calu_pkg::KIND_RLCA, calu_pkg::KIND_RRCA, calu_pkg::KIND_RLA, calu_pkg::KIND_RRA: begin
        case (s1_r.rot)
          calu_pkg::ROT_RLC: begin
            s2_nxt.r_calc = {a[6:0], a[7]};
            s2_nxt.c      = a[7];
          end
          calu_pkg::ROT_RRC: begin
            s2_nxt.r_calc = {a[0], a[7:1]};
            s2_nxt.c      = a[0];
          end
          calu_pkg::ROT_RL: begin
            s2_nxt.r_calc = {a[6:0], fc};
            s2_nxt.c      = a[7];
          end
          calu_pkg::ROT_RR: begin
            s2_nxt.r_calc = {fc, a[7:1]};
            s2_nxt.c      = a[0];
          end
          calu_pkg::ROT_SLA: begin
            s2_nxt.r_calc = {a[6:0], 1'b0};
            s2_nxt.c      = a[7];
          end
          calu_pkg::ROT_SRA: begin
            s2_nxt.r_calc = {a[7], a[7:1]};
            s2_nxt.c      = a[0];
          end
          calu_pkg::ROT_SWAP: begin
            s2_nxt.r_calc = {a[3:0], a[7:4]};
            s2_nxt.c      = 1'b0;
          end
          default: begin
            s2_nxt.r_calc = {1'b0, a[7:1]};
            s2_nxt.c      = a[0];
          end
        endcase
        // The accumulator forms always clear Z.
        s2_nxt.z_from_r = (s1_r.kind < calu_pkg::KIND_RLCA);
        s2_nxt.z_fixed  = 1'b0;
        s2_nxt.n        = 1'b0;
        s2_nxt.h        = 1'b0;
      end
      calu_pkg::KIND_BIT: begin
        s2_nxt.z_fixed = !a[s1_r.bidx];
        s2_nxt.n       = 1'b0;
        s2_nxt.h       = 1'b1;
        s2_nxt.wrt     = 1'b0;
      end
      calu_pkg::KIND_RES: begin
        s2_nxt.r_calc = a & ~(8'd1 << s1_r.bidx);
      end
      calu_pkg::KIND_SET: begin
        s2_nxt.r_calc = a | (8'd1 << s1_r.bidx);
      end
      calu_pkg::KIND_DAA: begin
        s2_nxt.r_calc   = fn ? (a - s1_r.daa_adj) : (a + s1_r.daa_adj);
        s2_nxt.z_from_r = 1'b1;
        s2_nxt.h        = 1'b0;
        s2_nxt.c        = s1_r.daa_c;
      end
      calu_pkg::KIND_CPL: begin
        s2_nxt.r_calc = ~a;
        s2_nxt.n      = 1'b1;
        s2_nxt.h      = 1'b1;
      end
      calu_pkg::KIND_SCF, calu_pkg::KIND_CCF: begin
        s2_nxt.r_calc = a;
        s2_nxt.n      = 1'b0;
        s2_nxt.h      = 1'b0;
        s2_nxt.c      = (s1_r.kind == calu_pkg::KIND_SCF) ? 1'b1 : !fc;
        s2_nxt.wrt    = 1'b0;
      end
      calu_pkg::KIND_ADD16: begin
        s2_nxt.wr = sum17[15:0];
        s2_nxt.n  = 1'b0;
        s2_nxt.h  = s1_r.h_wide;
        s2_nxt.c  = sum17[16];
      end
      calu_pkg::KIND_ADDSP: begin
        s2_nxt.wr      = s1_r.wa + {{8{s1_r.b[7]}}, s1_r.b};
        s2_nxt.z_fixed = 1'b0;
        s2_nxt.n       = 1'b0;
        s2_nxt.h       = s1_r.sp_h;
        s2_nxt.c       = s1_r.sp_c;
      end
      default: begin
        // The unused code leaves the flags alone and writes nothing.
        s2_nxt.wrt = 1'b0;
      end
    endcase
  end

  // Stage 3: zero detect and packing of the result item.
  always_comb begin
    logic z;
    z = s2_r.z_from_r ? (s2_r.r_calc == 8'd0) : s2_r.z_fixed;
    s3_nxt.result      = s2_r.clear_r ? 8'd0 : s2_r.r_calc;
    s3_nxt.wide_result = s2_r.wr;
    s3_nxt.flags       = {z, s2_r.n, s2_r.h, s2_r.c};
    s3_nxt.writes      = s2_r.wrt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_ch.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= s1_nxt;
    end
    if (en2) begin
      s2_r <= s2_nxt;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_ch.valid         = v3_r;
  assign out_ch.result        = s3_r.result;
  assign out_ch.wide_result   = s3_r.wide_result;
  assign out_ch.flags_out     = s3_r.flags;
  assign out_ch.writes_result = s3_r.writes;

  // Input back-pressure only appears once every stage holds an item.
  a_full_when_blocked: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r)
  ) else $error("input stalled while a pipeline stage is empty");

  // A held output keeps the middle stage occupied; nothing drains past it.
  a_mid_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (v2_r && v3_r && !out_ch.ready) |=> v2_r
  ) else $error("middle stage lost its item during a stall");

  // Byte and 16-bit results never both carry a value.
  a_result_exclusive: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.wide_result != 16'd0)) |-> (out_ch.result == 8'd0)
  ) else $error("byte result set together with a 16-bit result");

endmodule

FILE: tb/cpu_alu_with_flags_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the CPU ALU with flags. Operations go in on in_ch
// and results come back on out_ch. A predictor inside the bench computes the
// result of every accepted operation and queues it. Each result transfer on
// out_ch is then checked, field by field, against the oldest queued entry.
module cpu_alu_with_flags_tb;

  // Kind 31 has no operation behind it. The block must still answer it with
  // a zero result, the flags passed through and no write.
  localparam logic [calu_pkg::KIND_W-1:0] KIND_UNUSED = 5'd31;

  typedef struct packed {
    logic [calu_pkg::KIND_W-1:0]  kind;
    logic [calu_pkg::BYTE_W-1:0]  a;
    logic [calu_pkg::BYTE_W-1:0]  b;
    logic [calu_pkg::BIDX_W-1:0]  bidx;
    logic [calu_pkg::FLAGS_W-1:0] flags;
    logic [calu_pkg::WIDE_W-1:0]  wa;
    logic [calu_pkg::WIDE_W-1:0]  wb;
  } alu_op_t;

  typedef struct packed {
    logic [calu_pkg::BYTE_W-1:0]  result;
    logic [calu_pkg::WIDE_W-1:0]  wide_result;
    logic [calu_pkg::FLAGS_W-1:0] flags;
    logic                         writes;
  } alu_res_t;

  logic clk;
  logic rst_n;

  calu_in_if  in_ch ();
  calu_out_if out_ch ();

  cpu_alu_with_flags dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Results that the predictor has computed and the block has not yet
  // returned, oldest first.
  alu_res_t    pending_results[$];
  int unsigned mismatch_count;

  // Idle rates of the current phase, in percent per cycle.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The limit sits far above the slowest correct run, so only a hang or lost
  // results can reach it.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [calu_pkg::FLAGS_W-1:0] pack_flags(logic z, logic n, logic h,
                                                               logic c);
    logic [calu_pkg::FLAGS_W-1:0] f;
    f = '0;
    f[calu_pkg::FLAG_Z] = z;
    f[calu_pkg::FLAG_N] = n;
    f[calu_pkg::FLAG_H] = h;
    f[calu_pkg::FLAG_C] = c;
    return f;
  endfunction

  // Computes what the ALU must return for one operation.
  function automatic alu_res_t predict_alu(alu_op_t op);
    alu_res_t                    res;
    logic                        cin;
    logic                        cy;
    logic                        n_in;
    logic [8:0]                  sum9;
    logic [12:0]                 sum13;
    logic [16:0]                 sum17;
    logic [4:0]                  nib;
    logic [4:0]                  rot_sel;
    logic [calu_pkg::BYTE_W-1:0] adj;
    logic [calu_pkg::WIDE_W-1:0] ext;
    calu_pkg::rot_t              rot;
    res.result      = '0;
    res.wide_result = '0;
    res.flags       = op.flags;
    res.writes      = 1'b1;
    cin = op.flags[calu_pkg::FLAG_C];
    case (op.kind)
      calu_pkg::KIND_ADD, calu_pkg::KIND_ADC: begin
        cy   = (op.kind == calu_pkg::KIND_ADC) ? cin : 1'b0;
        sum9 = {1'b0, op.a} + {1'b0, op.b} + 9'(cy);
        nib  = {1'b0, op.a[3:0]} + {1'b0, op.b[3:0]} + 5'(cy);
        res.result = sum9[7:0];
        res.flags  = pack_flags(sum9[7:0] == '0, 1'b0, nib[4], sum9[8]);
      end
      calu_pkg::KIND_SUB, calu_pkg::KIND_SBC, calu_pkg::KIND_CP: begin
        cy   = (op.kind == calu_pkg::KIND_SBC) ? cin : 1'b0;
        sum9 = {1'b0, op.a} - {1'b0, op.b} - 9'(cy);
        res.result = sum9[7:0];
        res.flags  = pack_flags(sum9[7:0] == '0, 1'b1,
                                {1'b0, op.a[3:0]} < ({1'b0, op.b[3:0]} + 5'(cy)),
                                {1'b0, op.a} < ({1'b0, op.b} + 9'(cy)));
        if (op.kind == calu_pkg::KIND_CP) begin
          res.result = '0;
          res.writes = 1'b0;
        end
      end
      calu_pkg::KIND_AND: begin
        res.result = op.a & op.b;
        res.flags  = pack_flags(res.result == '0, 1'b0, 1'b1, 1'b0);
      end
      calu_pkg::KIND_XOR: begin
        res.result = op.a ^ op.b;
        res.flags  = pack_flags(res.result == '0, 1'b0, 1'b0, 1'b0);
      end
      calu_pkg::KIND_OR: begin
        res.result = op.a | op.b;
        res.flags  = pack_flags(res.result == '0, 1'b0, 1'b0, 1'b0);
      end
      calu_pkg::KIND_INC: begin
        res.result = op.a + 8'd1;
        res.flags  = pack_flags(res.result == '0, 1'b0, op.a[3:0] == 4'hF, cin);
      end
      calu_pkg::KIND_DEC: begin
        res.result = op.a - 8'd1;
        res.flags  = pack_flags(res.result == '0, 1'b1, op.a[3:0] == 4'h0, cin);
      end
      calu_pkg::KIND_RLC, calu_pkg::KIND_RRC, calu_pkg::KIND_RL, calu_pkg::KIND_RR,
      calu_pkg::KIND_SLA, calu_pkg::KIND_SRA, calu_pkg::KIND_SWAP, calu_pkg::KIND_SRL,
      calu_pkg::KIND_RLCA, calu_pkg::KIND_RRCA, calu_pkg::KIND_RLA,
      calu_pkg::KIND_RRA: begin
        // The accumulator rotates share the CB flavors but never set Z.
        rot_sel = (op.kind >= calu_pkg::KIND_RLCA) ? op.kind - calu_pkg::KIND_RLCA
                                                   : op.kind - calu_pkg::KIND_RLC;
        rot     = calu_pkg::rot_t'(rot_sel[2:0]);
        case (rot)
          calu_pkg::ROT_RLC: begin
            cy = op.a[7];
            res.result = {op.a[6:0], op.a[7]};
          end
          calu_pkg::ROT_RRC: begin
            cy = op.a[0];
            res.result = {op.a[0], op.a[7:1]};
          end
          calu_pkg::ROT_RL: begin
            cy = op.a[7];
            res.result = {op.a[6:0], cin};
          end
          calu_pkg::ROT_RR: begin
            cy = op.a[0];
            res.result = {cin, op.a[7:1]};
          end
          calu_pkg::ROT_SLA: begin
            cy = op.a[7];
            res.result = {op.a[6:0], 1'b0};
          end
          calu_pkg::ROT_SRA: begin
            cy = op.a[0];
            res.result = {op.a[7], op.a[7:1]};
          end
          calu_pkg::ROT_SWAP: begin
            cy = 1'b0;
            res.result = {op.a[3:0], op.a[7:4]};
          end
          default: begin
            cy = op.a[0];
            res.result = {1'b0, op.a[7:1]};
          end
        endcase
        res.flags = pack_flags(op.kind < calu_pkg::KIND_RLCA && res.result == '0,
                               1'b0, 1'b0, cy);
      end
      calu_pkg::KIND_BIT: begin
        res.flags  = pack_flags(!op.a[op.bidx], 1'b0, 1'b1, cin);
        res.writes = 1'b0;
      end
      calu_pkg::KIND_RES: res.result = op.a & ~(8'd1 << op.bidx);
      calu_pkg::KIND_SET: res.result = op.a | (8'd1 << op.bidx);
      calu_pkg::KIND_DAA: begin
        adj  = '0;
        n_in = op.flags[calu_pkg::FLAG_N];
        cy   = cin;
        if (op.flags[calu_pkg::FLAG_H] || (!n_in && op.a[3:0] > 4'd9)) adj = adj | 8'h06;
        if (cin || (!n_in && op.a > 8'h99)) begin
          adj = adj | 8'h60;
          cy  = 1'b1;
        end
        res.result = n_in ? op.a - adj : op.a + adj;
        res.flags  = pack_flags(res.result == '0, n_in, 1'b0, cy);
      end
      calu_pkg::KIND_CPL: begin
        res.result = ~op.a;
        res.flags[calu_pkg::FLAG_N] = 1'b1;
        res.flags[calu_pkg::FLAG_H] = 1'b1;
      end
      calu_pkg::KIND_SCF: begin
        res.result = op.a;
        res.flags  = pack_flags(op.flags[calu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1);
        res.writes = 1'b0;
      end
      calu_pkg::KIND_CCF: begin
        res.result = op.a;
        res.flags  = pack_flags(op.flags[calu_pkg::FLAG_Z], 1'b0, 1'b0, !cin);
        res.writes = 1'b0;
      end
      calu_pkg::KIND_ADD16: begin
        sum17 = {1'b0, op.wa} + {1'b0, op.wb};
        sum13 = {1'b0, op.wa[11:0]} + {1'b0, op.wb[11:0]};
        res.wide_result = sum17[15:0];
        res.flags = pack_flags(op.flags[calu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]);
      end
      calu_pkg::KIND_ADDSP: begin
        // H and C come from the unsigned low byte sum, not the signed one.
        ext  = {{8{op.b[7]}}, op.b};
        nib  = {1'b0, op.wa[3:0]} + {1'b0, op.b[3:0]};
        sum9 = {1'b0, op.wa[7:0]} + {1'b0, op.b};
        res.wide_result = op.wa + ext;
        res.flags = pack_flags(1'b0, 1'b0, nib[4], sum9[8]);
      end
      default: res.writes = 1'b0;
    endcase
    return res;
  endfunction

  function automatic alu_op_t make_op(logic [calu_pkg::KIND_W-1:0] kind,
                                      logic [calu_pkg::BYTE_W-1:0] a,
                                      logic [calu_pkg::BYTE_W-1:0] b,
                                      logic [calu_pkg::BIDX_W-1:0] bidx,
                                      logic [calu_pkg::FLAGS_W-1:0] flags,
                                      logic [calu_pkg::WIDE_W-1:0] wa,
                                      logic [calu_pkg::WIDE_W-1:0] wb);
    alu_op_t op;
    op.kind  = kind;
    op.a     = a;
    op.b     = b;
    op.bidx  = bidx;
    op.flags = flags;
    op.wa    = wa;
    op.wb    = wb;
    return op;
  endfunction

  // Bytes lean toward the values where carries, half carries and the DAA
  // thresholds change.
  function automatic logic [calu_pkg::BYTE_W-1:0] pick_byte();
    logic [31:0]                 raw;
    logic [calu_pkg::BYTE_W-1:0] v;
    raw = $urandom_range(255);
    v   = raw[calu_pkg::BYTE_W-1:0];
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = 8'h0F;
        3: v = 8'hF0;
        4: v = 8'h80;
        5: v = 8'h7F;
        6: v = 8'h99;
        default: v = 8'h9A;
      endcase
    end
    return v;
  endfunction

  function automatic logic [calu_pkg::WIDE_W-1:0] pick_wide();
    logic [31:0]                 raw;
    logic [calu_pkg::WIDE_W-1:0] v;
    raw = $urandom_range(65535);
    v   = raw[calu_pkg::WIDE_W-1:0];
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        2: v = 16'h0FFF;
        3: v = 16'h00FF;
        default: v = 16'h8000;
      endcase
    end
    return v;
  endfunction

  // Every kind is drawn, the unused one too, since the block answers them all.
  function automatic alu_op_t random_op();
    logic [31:0] kind_raw;
    logic [31:0] bidx_raw;
    logic [31:0] flags_raw;
    kind_raw  = $urandom_range(31);
    bidx_raw  = $urandom_range(7);
    flags_raw = $urandom_range(15);
    return make_op(kind_raw[calu_pkg::KIND_W-1:0], pick_byte(), pick_byte(),
                   bidx_raw[calu_pkg::BIDX_W-1:0], flags_raw[calu_pkg::FLAGS_W-1:0],
                   pick_wide(), pick_wide());
  endfunction

  // Offers one operation, idling first at the phase's rate, and queues its
  // predicted result once the transfer has happened. valid is left high so
  // that a following operation can go out on the very next cycle.
  task automatic send_op(alu_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= op.kind;
    in_ch.operand_a <= op.a;
    in_ch.operand_b <= op.b;
    in_ch.bit_index <= op.bidx;
    in_ch.flags_in  <= op.flags;
    in_ch.wide_a    <= op.wa;
    in_ch.wide_b    <= op.wb;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_alu(op));
  endtask

  // Holds the sender off until the block has returned everything in flight.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  // The receiver stalls at the phase's rate. A result is checked at each edge
  // where valid and ready were both high before the edge.
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transfer, expected none, got 0x%0h 0x%0h 0x%0h %0b",
                 $time, out_ch.result, out_ch.wide_result, out_ch.flags_out,
                 out_ch.writes_result);
      end else begin
        want = pending_results.pop_front();
        report_field("result", want.result, out_ch.result);
        report_field("wide_result", want.wide_result, out_ch.wide_result);
        report_field("flags_out", want.flags, out_ch.flags_out);
        report_field("writes_result", want.writes, out_ch.writes_result);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Add, subtract and the logic group at the carry, half carry and zero
  // corners, plus increment and decrement at the byte wrap.
  task automatic test_byte_arith();
    send_op(make_op(calu_pkg::KIND_ADD, 8'hFF, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_ADC, 8'h0F, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_SUB, 8'h00, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_SBC, 8'h10, 8'h0F, 3'd0, 4'h1, 16'hFFFF, 16'hFFFF));
    send_op(make_op(calu_pkg::KIND_AND, 8'h0F, 8'hF0, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_XOR, 8'hFF, 8'hFF, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_OR,  8'h00, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    // Compare of equal bytes: Z is set, but the destination is not written.
    send_op(make_op(calu_pkg::KIND_CP,  8'h42, 8'h42, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_INC, 8'hFF, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_DEC, 8'h00, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
  endtask

  task automatic test_shifts();
    send_op(make_op(calu_pkg::KIND_RLC,  8'h80, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_RR,   8'h01, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_SRA,  8'h81, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_SWAP, 8'hF0, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    // A zero accumulator after an accumulator rotate still leaves Z clear.
    send_op(make_op(calu_pkg::KIND_RLCA, 8'h00, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_RRA,  8'h01, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000));
  endtask

  // Bit test, reset and set at the outer bit positions, both directions of
  // decimal adjust, and the complement and carry flag operations.
  task automatic test_bit_and_flag_ops();
    send_op(make_op(calu_pkg::KIND_BIT, 8'h7F, 8'h00, 3'd7, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_RES, 8'hFF, 8'h00, 3'd0, 4'h5, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_SET, 8'h00, 8'h00, 3'd7, 4'hA, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_DAA, 8'h9A, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_DAA, 8'h00, 8'h00, 3'd0, 4'h7, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_CPL, 8'h5A, 8'h00, 3'd0, 4'h9, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_SCF, 8'hA5, 8'h00, 3'd0, 4'hE, 16'h0000, 16'h0000));
    send_op(make_op(calu_pkg::KIND_CCF, 8'h3C, 8'h00, 3'd0, 4'h9, 16'h0000, 16'h0000));
  endtask

  // The 16-bit adds at both carry points, the offset add with a negative
  // offset, and the unused kind.
  task automatic test_wide_ops();
    send_op(make_op(calu_pkg::KIND_ADD16, 8'hFF, 8'hFF, 3'd0, 4'h8, 16'hFFFF, 16'h0001));
    send_op(make_op(calu_pkg::KIND_ADD16, 8'h00, 8'h00, 3'd0, 4'h7, 16'h0FFF, 16'h0001));
    send_op(make_op(calu_pkg::KIND_ADDSP, 8'h00, 8'h01, 3'd0, 4'hF, 16'hFFFF, 16'h0000));
    send_op(make_op(calu_pkg::KIND_ADDSP, 8'hFF, 8'h80, 3'd0, 4'h0, 16'h0000, 16'hFFFF));
    send_op(make_op(KIND_UNUSED, 8'hFF, 8'hFF, 3'd7, 4'hF, 16'hFFFF, 16'hFFFF));
  endtask

  // Random operations under one idling setting. With hold_midway set, the
  // sender stops halfway until every outstanding result has come back.
  task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                     int unsigned recv_pct, bit hold_midway);
    set_idling(send_pct, recv_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) wait_until_drained();
      send_op(random_op());
    end
  endtask

  initial begin
    mismatch_count = 0;
    set_idling(0, 0);
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= '0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    in_ch.bit_index <= '0;
    in_ch.flags_in  <= '0;
    in_ch.wide_a    <= '0;
    in_ch.wide_b    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners go back to back with the receiver always ready.
    test_byte_arith();
    test_shifts();
    test_bit_and_flag_ops();
    test_wide_ops();

    test_random_traffic(500, 0, 0, 1'b0);
    test_random_traffic(480, 64, 0, 1'b0);
    test_random_traffic(480, 0, 64, 1'b1);
    test_random_traffic(480, 34, 34, 1'b0);

    // Let the pipeline empty, then keep watching out_ch for any result that
    // should not be there.
    wait_until_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
